@@ rtl/olad_pkg.sv @@
package olad_pkg;

   localparam int LIST_DEPTH_DEFAULT = 16;

   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   localparam logic [ACTION_W-1:0] ACT_APPEND  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DISPLAY = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   typedef logic [ACTION_W-1:0]        action_type;
   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic [STATUS_W-1:0]        status_type;

endpackage

@@ rtl/olad_if.sv @@
interface olad_req_if;
   logic                valid;
   logic                ready;
   olad_pkg::action_type action;
   olad_pkg::value_type  value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface olad_rsp_if;
   logic                 valid;
   logic                 ready;
   olad_pkg::value_type  item_value;
   olad_pkg::status_type status;
   logic                 last_of_run;

   modport source (output valid, output item_value, output status, output last_of_run,
                   input ready);
   modport sink   (input valid, input item_value, input status, input last_of_run,
                   output ready);
endinterface

@@ rtl/ordered_list_append_delete_unit.sv @@
// channel   | direction | payload                           | transfer when
// ----------+-----------+-----------------------------------+---------------------
// req_ch    | in        | action[1:0], value[31:0] signed   | valid && ready
// rsp_ch    | out       | item_value[31:0], status, last    | valid && ready
//
// Delete search and compaction together visit each valid entry once through the single
// memory read port. Display gives one result per cycle while rsp_ch is not stalled,
// with one memory read per entry.
// Reset clears the entry count, the sequencer and the result valid; entry storage
// is not cleared. A stalled result channel holds the sequencer in S_DISP or S_EMIT; req_ch is ready only
// between commands.
module ordered_list_append_delete_unit #(
   parameter int LIST_DEPTH = olad_pkg::LIST_DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   olad_req_if.sink  req_ch,
   olad_rsp_if.source rsp_ch
);

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SEARCH = 5'b00010,
      S_SHIFT  = 5'b00100,
      S_DISP   = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   olad_pkg::value_type  val_ff, val_in;
   olad_pkg::status_type emit_status_ff, emit_status_in;

   olad_pkg::value_type  store_ff [LIST_DEPTH];
   olad_pkg::value_type  rd_data_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_wa;
   olad_pkg::value_type  mem_wd;

   logic                 rsp_valid_ff;
   olad_pkg::value_type  rsp_item_ff, rsp_item_in;
   olad_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 push;
   logic                 out_free;

   logic [IDX_W-1:0]     idx_p1, idx_p2;
   logic [CNT_W-1:0]     idx_p1_cnt, idx_p2_cnt;

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign idx_p1     = idx_ff + IDX_W'(1);
   assign idx_p2     = idx_ff + IDX_W'(2);
   assign idx_p1_cnt = CNT_W'(idx_ff) + CNT_ONE;
   assign idx_p2_cnt = CNT_W'(idx_ff) + CNT_TWO;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      val_in         = val_ff;
      emit_status_in = emit_status_ff;
      rd_addr        = idx_ff;
      mem_we         = 1'b0;
      mem_wa         = idx_ff;
      mem_wd         = rd_data_ff;
      push           = 1'b0;
      rsp_item_in    = '0;
      rsp_status_in  = olad_pkg::ST_OK;
      rsp_last_in    = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (req_ch.valid) begin
               val_in = req_ch.value;
               idx_in = '0;
               unique case (req_ch.action)
                  olad_pkg::ACT_APPEND: begin
                     state_in = S_EMIT;
                     if (cnt_ff == CNT_FULL) begin
                        emit_status_in = olad_pkg::ST_FULL;
                     end else begin
                        mem_we         = 1'b1;
                        mem_wa         = cnt_ff[IDX_W-1:0];
                        mem_wd         = req_ch.value;
                        cnt_in         = cnt_ff + CNT_ONE;
                        emit_status_in = olad_pkg::ST_OK;
                     end
                  end
                  olad_pkg::ACT_DELETE: begin
                     if (cnt_ff == '0) begin
                        emit_status_in = olad_pkg::ST_EMPTY;
                        state_in       = S_EMIT;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  olad_pkg::ACT_DISPLAY: begin
                     if (cnt_ff == '0) begin
                        emit_status_in = olad_pkg::ST_EMPTY;
                        state_in       = S_EMIT;
                     end else begin
                        state_in = S_DISP;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (rd_data_ff == val_ff) begin
               if (idx_p1_cnt == cnt_ff) begin
                  cnt_in         = cnt_ff - CNT_ONE;
                  emit_status_in = olad_pkg::ST_OK;
                  state_in       = S_EMIT;
               end else begin
                  rd_addr  = idx_p1;
                  state_in = S_SHIFT;
               end
            end else if (idx_p1_cnt == cnt_ff) begin
               emit_status_in = olad_pkg::ST_NOT_FOUND;
               state_in       = S_EMIT;
            end else begin
               idx_in  = idx_p1;
               rd_addr = idx_p1;
            end
         end
         S_SHIFT: begin
            mem_we = 1'b1;
            mem_wa = idx_ff;
            mem_wd = rd_data_ff;
            if (idx_p2_cnt == cnt_ff) begin
               cnt_in         = cnt_ff - CNT_ONE;
               emit_status_in = olad_pkg::ST_OK;
               state_in       = S_EMIT;
            end else begin
               idx_in  = idx_p1;
               rd_addr = idx_p2;
            end
         end
         S_DISP: begin
            if (out_free) begin
               push          = 1'b1;
               rsp_item_in   = rd_data_ff;
               rsp_status_in = olad_pkg::ST_OK;
               rsp_last_in   = (idx_p1_cnt == cnt_ff);
               if (idx_p1_cnt == cnt_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in  = idx_p1;
                  rd_addr = idx_p1;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               push          = 1'b1;
               rsp_status_in = emit_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      val_ff         <= val_in;
      emit_status_ff <= emit_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_item_ff   <= rsp_item_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.item_value  = rsp_item_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.last_of_run = rsp_last_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("entry count above list depth");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && cnt_ff != $past(cnt_ff)) |->
         (cnt_ff == $past(cnt_ff) + CNT_ONE || cnt_ff == $past(cnt_ff) - CNT_ONE))
      else $error("entry count moved by more than one");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (idx_p2_cnt <= cnt_ff))
      else $error("compaction beyond valid entries");

   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("single result not delivered to output register");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result register overwritten while held");

endmodule
